FILE: src/vsmsf_pkg.sv
// shared types and constants of the vital-sign median and slew filter
package vsmsf_pkg;

   localparam int WINDOW_DEPTH_DEFAULT = 5;

   localparam int RAW_W       = 11;
   localparam int IR_W        = 18;
   localparam int HR_W        = 8;
   localparam int SPO2_W      = 7;
   localparam int HOLD_W      = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 18;

   localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

   // fixed admission bounds, compared on the magnitude of a non-negative raw value
   localparam logic [RAW_W-2:0] HR_ABS_LOW    = 10'd30;
   localparam logic [RAW_W-2:0] HR_ABS_HIGH   = 10'd220;
   localparam logic [RAW_W-2:0] SPO2_ABS_LOW  = 10'd70;
   localparam logic [RAW_W-2:0] SPO2_ABS_HIGH = 10'd100;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FINGER_THRESHOLD = 3'd0,
      REG_HR_STEP_LIMIT    = 3'd1,
      REG_HR_HOLD_LIMIT    = 3'd2,
      REG_SPO2_STEP_LIMIT  = 3'd3,
      REG_SPO2_HOLD_LIMIT  = 3'd4,
      REG_HR_PLAUSIBLE_MIN = 3'd5,
      REG_HR_PLAUSIBLE_MAX = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [IR_W-1:0]   presence_threshold;
      logic [HR_W-1:0]   hr_step_limit;
      logic [HOLD_W-1:0] hr_hold_limit;
      logic [SPO2_W-1:0] spo2_step_limit;
      logic [HOLD_W-1:0] spo2_hold_limit;
      logic [HR_W-1:0]   hr_plausible_min;
      logic [HR_W-1:0]   hr_plausible_max;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      presence_threshold: 18'd50000,
      hr_step_limit:      8'd20,
      hr_hold_limit:      4'd5,
      spo2_step_limit:    7'd5,
      spo2_hold_limit:    4'd5,
      hr_plausible_min:   8'd40,
      hr_plausible_max:   8'd150
   };

endpackage

FILE: src/vital_sign_median_slew_filter.sv
// top level of the vital-sign median and slew filter
//
// usage:
//   req_* carries one raw heart-rate estimate, one raw SpO2 estimate, their
//   ok flags and the IR mean; a transfer happens when req_valid is high and
//   req_stall is low. rsp_* returns one result per request transfer, in order.
//   csr_* writes the seven configuration registers; csr_ready is always high
//   and writes are to be made only while no item is in flight; the block
//   does not enforce this. A transferred request is registered in the input
//   register, filtered, and registered again in the result register on rsp_*.
// throughput: one item per cycle while no stall holds the result; the median
//   rank compare over the window and the step compare sit between the input
//   register and the result register, and each channel state updates as an
//   item leaves the input register.
// reset: synchronous, clears both pipeline valids and the channel state (all
//   but the window samples) and loads the register defaults.
// stall: while rsp_stall holds a result, one more item can wait in the input
//   register; after that req_stall rises.
module vital_sign_median_slew_filter #(
   parameter int WINDOW_DEPTH = vsmsf_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [vsmsf_pkg::RAW_W-1:0] req_raw_heart_rate,
   input  logic                              req_raw_hr_ok,
   input  logic signed [vsmsf_pkg::RAW_W-1:0] req_raw_oxygen,
   input  logic                              req_raw_oxygen_ok,
   input  logic [vsmsf_pkg::IR_W-1:0]        req_ir_mean,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [vsmsf_pkg::HR_W-1:0]        rsp_heart_rate,
   output logic                              rsp_heart_rate_ok,
   output logic [vsmsf_pkg::SPO2_W-1:0]      rsp_oxygen,
   output logic                              rsp_oxygen_ok,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [vsmsf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [vsmsf_pkg::CSR_DATA_W-1:0]  csr_data
);
   import vsmsf_pkg::*;

   cfg_type cfg;

   logic                    in_vld_ff, in_vld_in;
   logic signed [RAW_W-1:0] hr_raw_ff, ox_raw_ff;
   logic                    hr_raw_ok_ff, ox_raw_ok_ff;
   logic [IR_W-1:0]         ir_ff;

   logic                    out_vld_ff, out_vld_in;
   logic [HR_W-1:0]         hr_out_ff;
   logic                    hr_ok_out_ff;
   logic [SPO2_W-1:0]       ox_out_ff;
   logic                    ox_ok_out_ff;

   logic out_ready, advance, finger, hr_admit, ox_admit;
   logic [HR_W-1:0]   hr_pub;
   logic [SPO2_W-1:0] ox_pub;
   logic hr_pub_ok, ox_pub_ok;

   vsmsf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign out_ready = !out_vld_ff || !rsp_stall;
   assign advance   = in_vld_ff && out_ready;
   assign req_stall = in_vld_ff && !out_ready;
   assign in_vld_in = req_stall ? in_vld_ff : req_valid;
   assign out_vld_in = out_ready ? in_vld_ff : out_vld_ff;

   assign finger = ir_ff > cfg.presence_threshold;

   assign hr_admit = hr_raw_ok_ff && !hr_raw_ff[RAW_W-1]
                     && (hr_raw_ff[RAW_W-2:0] > HR_ABS_LOW)
                     && (hr_raw_ff[RAW_W-2:0] < HR_ABS_HIGH)
                     && (hr_raw_ff[RAW_W-2:0] >= (RAW_W-1)'(cfg.hr_plausible_min))
                     && (hr_raw_ff[RAW_W-2:0] <= (RAW_W-1)'(cfg.hr_plausible_max));

   assign ox_admit = ox_raw_ok_ff && !ox_raw_ff[RAW_W-1]
                     && (ox_raw_ff[RAW_W-2:0] >= SPO2_ABS_LOW)
                     && (ox_raw_ff[RAW_W-2:0] <= SPO2_ABS_HIGH);

   vsmsf_channel #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .VALUE_W      (HR_W)
   ) u_hr (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .clear      (!finger),
      .admit      (hr_admit),
      .value      (hr_raw_ff[HR_W-1:0]),
      .step_limit (cfg.hr_step_limit),
      .hold_limit (cfg.hr_hold_limit),
      .pub_value  (hr_pub),
      .pub_ok     (hr_pub_ok)
   );

   vsmsf_channel #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .VALUE_W      (SPO2_W)
   ) u_ox (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .clear      (!finger),
      .admit      (ox_admit),
      .value      (ox_raw_ff[SPO2_W-1:0]),
      .step_limit (cfg.spo2_step_limit),
      .hold_limit (cfg.spo2_hold_limit),
      .pub_value  (ox_pub),
      .pub_ok     (ox_pub_ok)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         hr_raw_ff    <= req_raw_heart_rate;
         hr_raw_ok_ff <= req_raw_hr_ok;
         ox_raw_ff    <= req_raw_oxygen;
         ox_raw_ok_ff <= req_raw_oxygen_ok;
         ir_ff        <= req_ir_mean;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hr_out_ff    <= finger ? hr_pub : '0;
         hr_ok_out_ff <= finger && hr_pub_ok;
         ox_out_ff    <= finger ? ox_pub : '0;
         ox_ok_out_ff <= finger && ox_pub_ok;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_heart_rate    = hr_out_ff;
   assign rsp_heart_rate_ok = hr_ok_out_ff;
   assign rsp_oxygen        = ox_out_ff;
   assign rsp_oxygen_ok     = ox_ok_out_ff;

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled while result stage could move");

   a_invalid_hr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_heart_rate_ok) |-> (rsp_heart_rate == '0))
      else $error("invalid heart rate not shown as zero");

   a_oxygen_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_oxygen_ok) |->
         ((rsp_oxygen >= SPO2_W'(70)) && (rsp_oxygen <= SPO2_W'(100))))
      else $error("published oxygen outside admitted range");
`endif

endmodule

FILE: src/vsmsf_csr.sv
// configuration register file of the vital-sign filter
module vsmsf_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [vsmsf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [vsmsf_pkg::CSR_DATA_W-1:0]  csr_data,
   output vsmsf_pkg::cfg_type               cfg
);
   import vsmsf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            REG_FINGER_THRESHOLD: cfg_in.presence_threshold = csr_data[IR_W-1:0];
            REG_HR_STEP_LIMIT:    cfg_in.hr_step_limit      = csr_data[HR_W-1:0];
            REG_HR_HOLD_LIMIT:    cfg_in.hr_hold_limit      = csr_data[HOLD_W-1:0];
            REG_SPO2_STEP_LIMIT:  cfg_in.spo2_step_limit    = csr_data[SPO2_W-1:0];
            REG_SPO2_HOLD_LIMIT:  cfg_in.spo2_hold_limit    = csr_data[HOLD_W-1:0];
            REG_HR_PLAUSIBLE_MIN: cfg_in.hr_plausible_min   = csr_data[HR_W-1:0];
            REG_HR_PLAUSIBLE_MAX: cfg_in.hr_plausible_max   = csr_data[HR_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: src/vsmsf_channel.sv
// one channel: median window, step limiter and hold counter
module vsmsf_channel #(
   parameter int WINDOW_DEPTH = vsmsf_pkg::WINDOW_DEPTH_DEFAULT,
   parameter int VALUE_W      = vsmsf_pkg::HR_W
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          clear,
   input  logic                          admit,
   input  logic [VALUE_W-1:0]            value,
   input  logic [VALUE_W-1:0]            step_limit,
   input  logic [vsmsf_pkg::HOLD_W-1:0]  hold_limit,
   output logic [VALUE_W-1:0]            pub_value,
   output logic                          pub_ok
);
   import vsmsf_pkg::*;

   localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
   localparam int IDX_W  = $clog2(WINDOW_DEPTH);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_DEPTH);
   localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(WINDOW_DEPTH - 1);

   logic [VALUE_W-1:0] win_ff [WINDOW_DEPTH];
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [IDX_W-1:0]   widx_ff, widx_in;
   logic [VALUE_W-1:0] last_ff, last_in;
   logic               present_ff, present_in;
   logic [HOLD_W-1:0]  hold_ff, hold_in;

   logic [VALUE_W-1:0] win_new [WINDOW_DEPTH];
   logic [FILL_W-1:0]  rank [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0] slot_used;
   logic [FILL_W-1:0]  fill_new;
   logic [VALUE_W-1:0] median;
   logic [VALUE_W-1:0] diff;

   assign fill_new = (fill_ff == FILL_FULL) ? fill_ff : fill_ff + 1'b1;

   // median by rank: ties broken by slot position
   always_comb begin
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
         win_new[k]   = (widx_ff == IDX_W'(k)) ? value : win_ff[k];
         slot_used[k] = FILL_W'(k) < fill_new;
      end
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         rank[i] = '0;
         for (int j = 0; j < WINDOW_DEPTH; j++) begin
            if (slot_used[j] && ((win_new[j] < win_new[i]) ||
                                 ((win_new[j] == win_new[i]) && (j < i)))) begin
               rank[i] = rank[i] + 1'b1;
            end
         end
      end
      median = '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         if (slot_used[i] && (rank[i] == (fill_new >> 1))) begin
            median = win_new[i];
         end
      end
   end

   assign diff = (median >= last_ff) ? median - last_ff : last_ff - median;

   always_comb begin
      fill_in    = fill_ff;
      widx_in    = widx_ff;
      last_in    = last_ff;
      present_in = present_ff;
      hold_in    = hold_ff;
      if (admit) begin
         fill_in = fill_new;
         widx_in = (widx_ff == IDX_LAST) ? '0 : widx_ff + 1'b1;
         if (!present_ff) begin
            last_in    = median;
            present_in = 1'b1;
            hold_in    = '0;
         end else if ((diff <= step_limit) || (hold_ff >= hold_limit)) begin
            last_in = median;
            hold_in = '0;
         end else if (hold_ff != HOLD_MAX) begin
            hold_in = hold_ff + 1'b1;
         end
      end
   end

   assign pub_ok    = admit | present_ff;
   assign pub_value = admit ? last_in : (present_ff ? last_ff : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         widx_ff    <= '0;
         last_ff    <= '0;
         present_ff <= 1'b0;
         hold_ff    <= '0;
      end else if (advance) begin
         if (clear) begin
            fill_ff    <= '0;
            widx_ff    <= '0;
            last_ff    <= '0;
            present_ff <= 1'b0;
            hold_ff    <= '0;
         end else begin
            fill_ff    <= fill_in;
            widx_ff    <= widx_in;
            last_ff    <= last_in;
            present_ff <= present_in;
            hold_ff    <= hold_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && !clear && admit) begin
         win_ff[widx_ff] <= value;
      end
   end

endmodule
